### rtl/vector3_angle_top_assert.svh
// Assertion macros shared by the checker of the vector angle block.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef VECTOR3_ANGLE_TOP_ASSERT_SVH
`define VECTOR3_ANGLE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define V3A_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define V3A_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/v3a_pkg.sv
// Types, constants and elaboration-time helpers for the vector angle block.
// No dependencies; the files that use it refer to it by scoped names.
package v3a_pkg;

  localparam int DW          = 64;
  localparam int WW          = 128;
  localparam int ROOT_BITS   = 60;
  localparam int CORDIC_STEPS = 62;
  localparam int Q_FRAC      = 62;

  localparam logic [63:0] PI_Q62         = 64'hC90FDAA22168C235;
  localparam logic [63:0] QUARTER_PI_Q62 = 64'h3243F6A8885A308D;

  typedef logic [WW-1:0]        wide_t;
  typedef logic [DW-1:0]        word_t;
  typedef logic signed [DW-1:0] sword_t;
  typedef logic [ROOT_BITS-1:0] root_t;

  // Control that travels with each item down the chain.
  typedef struct packed {
    logic valid;
    logic dneg;
    logic zero;
  } tag_t;

  // Operand pairs of the three cross product terms: cx, cy, cz.
  localparam int CROSS_A [6] = '{1, 2, 2, 0, 0, 1};
  localparam int CROSS_B [6] = '{5, 4, 3, 5, 4, 3};

  // atan(2^-step) in Q62 by its power series, long division done bit by bit.
  function automatic word_t atan_q62(input int step);
    word_t acc;
    word_t term;
    word_t rem;
    word_t dv;
    int    ex;
    if (step == 0) begin
      return QUARTER_PI_Q62;
    end
    acc = '0;
    for (int k = 0; k < 63; k++) begin
      ex = 62 - step * (2 * k + 1);
      if (ex >= 0) begin
        dv   = word_t'(2 * k + 1);
        term = '0;
        rem  = '0;
        for (int j = 63; j >= 0; j--) begin
          rem = {rem[62:0], (j == ex)};
          if (rem >= dv) begin
            rem     = rem - dv;
            term[j] = 1'b1;
          end
        end
        acc = (k % 2 == 1) ? acc - term : acc + term;
      end
    end
    return acc;
  endfunction

  // Round a Q62 angle to nearest in Q(frac).
  function automatic word_t round_q62(input word_t q, input int frac);
    int sh;
    sh = Q_FRAC - frac;
    return (q + (word_t'(1) << (sh - 1))) >> sh;
  endfunction

  function automatic logic [7:0] bit_len_wide(input wide_t v);
    logic [7:0] n;
    n = '0;
    for (int i = 0; i < WW; i++) begin
      if (v[i]) n = 8'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [6:0] bit_len_word(input word_t v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < DW; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

endpackage

### rtl/v3a_front.sv
// Front end: sign/magnitude split, dot and cross products, the squared
// cross length and the common scaling. Seven stages. Uses v3a_pkg.
module v3a_front #(
  parameter int CB = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [CB-1:0]       comp [6],
  output v3a_pkg::tag_t       tag_o,
  output v3a_pkg::wide_t      sq_o,
  output v3a_pkg::word_t      x_o
);

  logic [CB-1:0]     mag [6];
  logic              sgn [6];
  logic [2*CB-1:0]   prd [9];

  v3a_pkg::word_t    p1_r [9];
  logic              s1_r [6];
  v3a_pkg::tag_t     t1_r, t2_r, t3_r, t4_r, t5_r, t6_r, t7_r;

  v3a_pkg::word_t    pos, negs, dm2_nxt;
  v3a_pkg::word_t    c2_nxt [3];
  v3a_pkg::word_t    c2_r [3];
  v3a_pkg::word_t    dm2_r, dm3_r, dm4_r, dm5_r, dm6_r;
  logic              dneg2;

  v3a_pkg::word_t    ll3_r [3], lh3_r [3], hh3_r [3];
  v3a_pkg::wide_t    sq4_r [3];
  v3a_pkg::wide_t    sq5_r, sq6_r;
  logic [7:0]        bs6_r;
  logic [6:0]        bd6_r;

  logic signed [10:0] es, ed, e, ne;
  v3a_pkg::wide_t    sq7_nxt, sq7_r;
  v3a_pkg::word_t    x7_nxt, x7_r;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      sgn[i] = comp[i][CB-1];
      mag[i] = sgn[i] ? (~comp[i] + CB'(1)) : comp[i];
    end
    for (int i = 0; i < 3; i++) begin
      prd[i] = mag[i] * mag[i+3];
    end
    for (int i = 0; i < 6; i++) begin
      prd[i+3] = mag[v3a_pkg::CROSS_A[i]] * mag[v3a_pkg::CROSS_B[i]];
    end
  end

  // Stage 2: signed sums of the products.
  always_comb begin
    pos  = '0;
    negs = '0;
    for (int i = 0; i < 3; i++) begin
      if (s1_r[i] != s1_r[i+3]) negs = negs + p1_r[i];
      else pos = pos + p1_r[i];
    end
    dneg2   = negs > pos;
    dm2_nxt = dneg2 ? negs - pos : pos - negs;
    for (int i = 0; i < 3; i++) begin
      if ((s1_r[v3a_pkg::CROSS_A[2*i]] != s1_r[v3a_pkg::CROSS_B[2*i]]) !=
          (s1_r[v3a_pkg::CROSS_A[2*i+1]] != s1_r[v3a_pkg::CROSS_B[2*i+1]])) begin
        c2_nxt[i] = p1_r[2*i+3] + p1_r[2*i+4];
      end else if (p1_r[2*i+3] > p1_r[2*i+4]) begin
        c2_nxt[i] = p1_r[2*i+3] - p1_r[2*i+4];
      end else begin
        c2_nxt[i] = p1_r[2*i+4] - p1_r[2*i+3];
      end
    end
  end

  // Stage 7: the larger leg gets about 60 significant bits.
  always_comb begin
    es = (bs6_r != '0) ? ((11'sd120 - $signed({3'b0, bs6_r})) >>> 1) : 11'sd1000;
    ed = (bd6_r != '0) ? (11'sd60 - $signed({4'b0, bd6_r})) : 11'sd1000;
    e  = (es < ed) ? es : ed;
    ne = -e;
    if (!e[10]) begin
      sq7_nxt = sq6_r << {e[9:0], 1'b0};
      x7_nxt  = dm6_r << e[9:0];
    end else begin
      sq7_nxt = sq6_r >> {ne[9:0], 1'b0};
      x7_nxt  = dm6_r >> ne[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r.valid <= 1'b0;
      t2_r.valid <= 1'b0;
      t3_r.valid <= 1'b0;
      t4_r.valid <= 1'b0;
      t5_r.valid <= 1'b0;
      t6_r.valid <= 1'b0;
      t7_r.valid <= 1'b0;
    end else if (en) begin
      t1_r.valid <= in_vld;
      t2_r.valid <= t1_r.valid;
      t3_r.valid <= t2_r.valid;
      t4_r.valid <= t3_r.valid;
      t5_r.valid <= t4_r.valid;
      t6_r.valid <= t5_r.valid;
      t7_r.valid <= t6_r.valid;
    end
    if (en) begin
      for (int i = 0; i < 9; i++) p1_r[i] <= v3a_pkg::word_t'(prd[i]);
      for (int i = 0; i < 6; i++) s1_r[i] <= sgn[i];
      t1_r.dneg <= 1'b0;
      t1_r.zero <= ((mag[0] | mag[1] | mag[2]) == '0) || ((mag[3] | mag[4] | mag[5]) == '0);

      t2_r.dneg <= dneg2;
      t2_r.zero <= t1_r.zero;
      dm2_r     <= dm2_nxt;
      c2_r      <= c2_nxt;

      for (int i = 0; i < 3; i++) begin
        ll3_r[i] <= c2_r[i][31:0] * c2_r[i][31:0];
        lh3_r[i] <= c2_r[i][31:0] * c2_r[i][63:32];
        hh3_r[i] <= c2_r[i][63:32] * c2_r[i][63:32];
      end
      t3_r.dneg <= t2_r.dneg;
      t3_r.zero <= t2_r.zero;
      dm3_r     <= dm2_r;

      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= {hh3_r[i], 64'b0} + ({64'b0, lh3_r[i]} << 33) + {64'b0, ll3_r[i]};
      end
      t4_r.dneg <= t3_r.dneg;
      t4_r.zero <= t3_r.zero;
      dm4_r     <= dm3_r;

      sq5_r     <= sq4_r[0] + sq4_r[1] + sq4_r[2];
      t5_r.dneg <= t4_r.dneg;
      t5_r.zero <= t4_r.zero;
      dm5_r     <= dm4_r;

      sq6_r     <= sq5_r;
      bs6_r     <= v3a_pkg::bit_len_wide(sq5_r);
      bd6_r     <= v3a_pkg::bit_len_word(dm5_r);
      t6_r.dneg <= t5_r.dneg;
      t6_r.zero <= t5_r.zero;
      dm6_r     <= dm5_r;

      sq7_r     <= sq7_nxt;
      x7_r      <= x7_nxt;
      t7_r.dneg <= t6_r.dneg;
      t7_r.zero <= t6_r.zero;
    end
  end

  assign tag_o = t7_r;
  assign sq_o  = sq7_r;
  assign x_o   = x7_r;

endmodule

### rtl/v3a_root_cell.sv
// One bit of the integer square root: tries bit STEP of the root against
// the running remainder. Uses v3a_pkg.
module v3a_root_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  v3a_pkg::tag_t  tag_i,
  input  v3a_pkg::wide_t rem_i,
  input  v3a_pkg::root_t root_i,
  input  v3a_pkg::word_t x_i,
  output v3a_pkg::tag_t  tag_o,
  output v3a_pkg::wide_t rem_o,
  output v3a_pkg::root_t root_o,
  output v3a_pkg::word_t x_o
);

  v3a_pkg::tag_t  tag_r;
  v3a_pkg::wide_t rem_r, rem_nxt, trial;
  v3a_pkg::root_t root_r, root_nxt;

  // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
  always_comb begin
    trial    = (v3a_pkg::wide_t'(root_i) << (STEP + 1)) + (v3a_pkg::wide_t'(1) << (2 * STEP));
    rem_nxt  = rem_i;
    root_nxt = root_i;
    if (trial <= rem_i) begin
      rem_nxt        = rem_i - trial;
      root_nxt[STEP] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end else if (en) begin
      tag_r.valid <= tag_i.valid;
    end
    if (en) begin
      tag_r.dneg <= tag_i.dneg;
      tag_r.zero <= tag_i.zero;
      rem_r      <= rem_nxt;
      root_r     <= root_nxt;
      x_o        <= x_i;
    end
  end

  assign tag_o  = tag_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

### rtl/v3a_cordic_cell.sv
// One vectoring CORDIC rotation by atan(2^-STEP), driving y toward zero
// and accumulating the angle in Q62. Uses v3a_pkg.
module v3a_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  v3a_pkg::tag_t   tag_i,
  input  v3a_pkg::sword_t x_i,
  input  v3a_pkg::sword_t y_i,
  input  v3a_pkg::sword_t z_i,
  output v3a_pkg::tag_t   tag_o,
  output v3a_pkg::sword_t x_o,
  output v3a_pkg::sword_t y_o,
  output v3a_pkg::sword_t z_o
);

  localparam v3a_pkg::word_t ATAN = v3a_pkg::atan_q62(STEP);

  v3a_pkg::tag_t   tag_r;
  v3a_pkg::sword_t xs, ys;

  assign xs = x_i >>> STEP;
  assign ys = y_i >>> STEP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end else if (en) begin
      tag_r.valid <= tag_i.valid;
    end
    if (en) begin
      tag_r.dneg <= tag_i.dneg;
      tag_r.zero <= tag_i.zero;
      if (!y_i[v3a_pkg::DW-1]) begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + $signed(ATAN);
      end else begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - $signed(ATAN);
      end
    end
  end

  assign tag_o = tag_r;

endmodule

### rtl/vector3_angle_top.sv
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | in_valid, in_stall, in_first_*, in_second_* | vector pair in
//  result  | out_valid, out_stall, out_angle, out_zero_length | angle out
//
// One item is taken every cycle while the chain advances; an item passes through
// 7 front stages, 60 root cells, 62 CORDIC cells and one output register.
// The chain advances as a whole; it holds only while a result sits in the
// output register and out_stall is high, and in_stall reflects exactly that.
// Synchronous reset clears the valid bits of every stage.
module vector3_angle_top #(
  parameter int COMPONENT_BITS  = 24,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [COMPONENT_BITS-1:0] in_first_x,
  input  logic signed [COMPONENT_BITS-1:0] in_first_y,
  input  logic signed [COMPONENT_BITS-1:0] in_first_z,
  input  logic signed [COMPONENT_BITS-1:0] in_second_x,
  input  logic signed [COMPONENT_BITS-1:0] in_second_y,
  input  logic signed [COMPONENT_BITS-1:0] in_second_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ANGLE_FRAC_BITS+1:0]     out_angle,
  output logic                           out_zero_length
);

  localparam int NR = v3a_pkg::ROOT_BITS;
  localparam int NC = v3a_pkg::CORDIC_STEPS;

  logic                      advance;
  logic [COMPONENT_BITS-1:0] comp [6];

  v3a_pkg::tag_t   rtag [NR+1];
  v3a_pkg::wide_t  rrem [NR+1];
  v3a_pkg::root_t  rroot [NR+1];
  v3a_pkg::word_t  rx [NR+1];

  v3a_pkg::tag_t   ctag [NC+1];
  v3a_pkg::sword_t cx [NC+1];
  v3a_pkg::sword_t cy [NC+1];
  v3a_pkg::sword_t cz [NC+1];

  v3a_pkg::word_t  zz, ans, rnd;
  logic            out_valid_r;
  logic [ANGLE_FRAC_BITS+1:0] out_angle_r;
  logic            out_zero_r;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  assign comp[0] = in_first_x;
  assign comp[1] = in_first_y;
  assign comp[2] = in_first_z;
  assign comp[3] = in_second_x;
  assign comp[4] = in_second_y;
  assign comp[5] = in_second_z;

  v3a_front #(.CB(COMPONENT_BITS)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .in_vld(in_valid),
    .comp  (comp),
    .tag_o (rtag[0]),
    .sq_o  (rrem[0]),
    .x_o   (rx[0])
  );

  assign rroot[0] = '0;

  for (genvar k = 0; k < NR; k++) begin : g_root
    v3a_root_cell #(.STEP(NR - 1 - k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (advance),
      .tag_i (rtag[k]),
      .rem_i (rrem[k]),
      .root_i(rroot[k]),
      .x_i   (rx[k]),
      .tag_o (rtag[k+1]),
      .rem_o (rrem[k+1]),
      .root_o(rroot[k+1]),
      .x_o   (rx[k+1])
    );
  end

  assign ctag[0] = rtag[NR];
  assign cx[0]   = $signed(rx[NR]);
  assign cy[0]   = $signed(v3a_pkg::word_t'(rroot[NR]));
  assign cz[0]   = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cordic
    v3a_cordic_cell #(.STEP(k)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (advance),
      .tag_i(ctag[k]),
      .x_i  (cx[k]),
      .y_i  (cy[k]),
      .z_i  (cz[k]),
      .tag_o(ctag[k+1]),
      .x_o  (cx[k+1]),
      .y_o  (cy[k+1]),
      .z_o  (cz[k+1])
    );
  end

  // Fold the first-quadrant angle back when the dot product was negative; a zero-length item gets pi/2.
  always_comb begin
    zz = cz[NC][v3a_pkg::DW-1] ? '0 : v3a_pkg::word_t'(cz[NC]);
    if (zz > v3a_pkg::PI_Q62) zz = v3a_pkg::PI_Q62;
    ans = ctag[NC].dneg ? v3a_pkg::PI_Q62 - zz : zz;
    if (ctag[NC].zero) ans = v3a_pkg::PI_Q62 >> 1;
    rnd = v3a_pkg::round_q62(ans, ANGLE_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= ctag[NC].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_angle_r <= rnd[ANGLE_FRAC_BITS+1:0];
      out_zero_r  <= ctag[NC].zero;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_angle       = out_angle_r;
  assign out_zero_length = out_zero_r;

endmodule

### rtl/vector3_angle_chk.sv
// Port-level checker for the vector angle block, bound to the top level.
// Uses v3a_pkg and the macros of vector3_angle_top_assert.svh.
`include "vector3_angle_top_assert.svh"

module vector3_angle_chk #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ANGLE_FRAC_BITS+1:0] out_angle,
  input logic                       out_zero_length
);

  localparam v3a_pkg::word_t HALF_W =
    v3a_pkg::round_q62(v3a_pkg::PI_Q62 >> 1, ANGLE_FRAC_BITS);
  localparam v3a_pkg::word_t PI_W =
    v3a_pkg::round_q62(v3a_pkg::PI_Q62, ANGLE_FRAC_BITS);
  localparam logic [ANGLE_FRAC_BITS+1:0] HALF_PI = HALF_W[ANGLE_FRAC_BITS+1:0];
  localparam logic [ANGLE_FRAC_BITS+1:0] PI_OUT  = PI_W[ANGLE_FRAC_BITS+1:0];

  `V3A_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `V3A_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
  `V3A_ASSERT_NOW(a_zero_angle, out_valid && out_zero_length, out_angle == HALF_PI)
  `V3A_ASSERT_NOW(a_angle_range, out_valid, out_angle <= PI_OUT)

endmodule

bind vector3_angle_top vector3_angle_chk #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_chk (.*);

### test/vector3_angle_checker.sv
// Checker for the vector angle block: predicts each angle from the accepted input items
// and compares it with the result items. Depends on v3a_pkg for the pi constants.
`timescale 1ns / 100ps

module vector3_angle_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [23:0] in_first_x,
  input  logic [23:0] in_first_y,
  input  logic [23:0] in_first_z,
  input  logic [23:0] in_second_x,
  input  logic [23:0] in_second_y,
  input  logic [23:0] in_second_z,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [17:0] out_angle,
  input  logic        out_zero_length,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [17:0] angle;
    logic        zero_length;
  } angle_res_t;

  localparam int STEPS = 62;

  longint atan_q62 [STEPS];
  angle_res_t angle_queue [$];

  initial begin
    longint acc;
    int ex;
    atan_q62[0] = longint'(v3a_pkg::QUARTER_PI_Q62);
    for (int i = 1; i < STEPS; i++) begin
      acc = 0;
      for (int k = 0; k < 64; k++) begin
        ex = 62 - i * (2 * k + 1);
        if (ex >= 0) begin
          if (k % 2 == 1) acc -= longint'((64'd1 << ex) / (2 * k + 1));
          else acc += longint'((64'd1 << ex) / (2 * k + 1));
        end
      end
      atan_q62[i] = acc;
    end
  end

  function automatic int bit_count(input logic [127:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 128; i++) begin
      if (v[i]) n = i + 1;
    end
    return n;
  endfunction

  function automatic logic [17:0] round_angle(input logic [63:0] q);
    logic [63:0] r;
    r = (q + (64'd1 << 45)) >> 46;
    return r[17:0];
  endfunction

  // Magnitude of a*b - c*d with each operand in sign/magnitude form.
  function automatic logic [63:0] cross_mag(input logic sa, sb, sc, sd,
                                            input logic [63:0] ma, mb, mc, md);
    logic [63:0] p1, p2;
    p1 = ma * mb;
    p2 = mc * md;
    if ((sa != sb) != (sc != sd)) return p1 + p2;
    return (p1 > p2) ? p1 - p2 : p2 - p1;
  endfunction

  function automatic angle_res_t predict_angle(input logic [23:0] comp [6]);
    logic        sgn [6];
    logic [63:0] mag [6];
    logic [63:0] pos, negsum, dmag, cx, cy, cz, zz, ans;
    logic [127:0] sq, root_sq, cand;
    logic        dneg;
    int bs, bd, es, ed, e, t;
    longint x, y, z, xs, ys;
    angle_res_t res;
    for (int i = 0; i < 6; i++) begin
      sgn[i] = comp[i][23];
      mag[i] = sgn[i] ? (64'd1 << 24) - {40'd0, comp[i]} : {40'd0, comp[i]};
    end
    if ((mag[0] | mag[1] | mag[2]) == 0 || (mag[3] | mag[4] | mag[5]) == 0) begin
      res.angle = round_angle(v3a_pkg::PI_Q62 >> 1);
      res.zero_length = 1'b1;
      return res;
    end
    pos = 0;
    negsum = 0;
    for (int i = 0; i < 3; i++) begin
      if (sgn[i] != sgn[i+3]) negsum += mag[i] * mag[i+3];
      else pos += mag[i] * mag[i+3];
    end
    dneg = negsum > pos;
    dmag = dneg ? negsum - pos : pos - negsum;
    cx = cross_mag(sgn[1], sgn[5], sgn[2], sgn[4], mag[1], mag[5], mag[2], mag[4]);
    cy = cross_mag(sgn[2], sgn[3], sgn[0], sgn[5], mag[2], mag[3], mag[0], mag[5]);
    cz = cross_mag(sgn[0], sgn[4], sgn[1], sgn[3], mag[0], mag[4], mag[1], mag[3]);
    sq = {64'd0, cx} * {64'd0, cx} + {64'd0, cy} * {64'd0, cy} + {64'd0, cz} * {64'd0, cz};
    // Scale both legs by a common power of two so the larger has about 60 bits.
    bs = bit_count(sq);
    bd = bit_count({64'd0, dmag});
    es = 1000;
    ed = 1000;
    if (bs != 0) begin
      t = 120 - bs;
      es = (t >= 0) ? t / 2 : -((1 - t) / 2);
    end
    if (bd != 0) ed = 60 - bd;
    e = (es < ed) ? es : ed;
    if (e >= 0) begin
      sq = sq << (2 * e);
      dmag = dmag << e;
    end else begin
      sq = sq >> (-2 * e);
      dmag = dmag >> (-e);
    end
    root_sq = 0;
    for (int b = 59; b >= 0; b--) begin
      cand = root_sq | (128'd1 << b);
      if (cand * cand <= sq) root_sq = cand;
    end
    y = longint'(root_sq[63:0]);
    x = longint'(dmag);
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += atan_q62[i];
      end else begin
        x -= ys;
        y += xs;
        z -= atan_q62[i];
      end
    end
    zz = (z < 0) ? 64'd0 : 64'(z);
    if (zz > v3a_pkg::PI_Q62) zz = v3a_pkg::PI_Q62;
    ans = dneg ? v3a_pkg::PI_Q62 - zz : zz;
    res.angle = round_angle(ans);
    res.zero_length = 1'b0;
    return res;
  endfunction

  assign pending = angle_queue.size();

  always @(posedge clk) begin
    logic [23:0] comp [6];
    angle_res_t exp_res;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        comp = '{in_first_x, in_first_y, in_first_z, in_second_x, in_second_y, in_second_z};
        angle_queue.push_back(predict_angle(comp));
      end
      if (out_valid && !out_stall) begin
        if (angle_queue.size() == 0) begin
          $error("unexpected result item: angle %0d zero_length %0b",
                 out_angle, out_zero_length);
          mismatches++;
        end else begin
          exp_res = angle_queue.pop_front();
          if (out_angle !== exp_res.angle) begin
            $error("angle: expected %0d, actual %0d", exp_res.angle, out_angle);
            mismatches++;
          end
          if (out_zero_length !== exp_res.zero_length) begin
            $error("zero_length: expected %0b, actual %0b",
                   exp_res.zero_length, out_zero_length);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

### test/vector3_angle_top_test.sv
// Testbench top for the vector angle block: drives directed and random vector pairs
// with random gaps and stalls. Depends on vector3_angle_top and vector3_angle_checker.
`timescale 1ns / 100ps

module vector3_angle_top_test;

  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT  = 600000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [23:0] in_first_x, in_first_y, in_first_z;
  logic [23:0] in_second_x, in_second_y, in_second_z;
  logic        out_valid;
  logic        out_stall;
  logic [17:0] out_angle;
  logic        out_zero_length;
  int          mismatches;
  int          pending;
  int          cycles;
  int          items_sent;

  vector3_angle_top u_dut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_first_x, .in_first_y, .in_first_z,
    .in_second_x, .in_second_y, .in_second_z,
    .out_valid, .out_stall, .out_angle, .out_zero_length
  );

  vector3_angle_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_first_x, .in_first_y, .in_first_z,
    .in_second_x, .in_second_y, .in_second_z,
    .out_valid, .out_stall, .out_angle, .out_zero_length,
    .mismatches, .pending
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_cycles();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [23:0] small_comp();
    return 24'($signed($urandom_range(0, 200)) - 100);
  endfunction

  function automatic logic [23:0] edge_comp();
    case ($urandom_range(4))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'h000000;
      3: return 24'h000001;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  task automatic send_pair(input logic [23:0] ax, ay, az, bx, by, bz);
    int gap;
    gap = (items_sent >= 220 && items_sent < 300) ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_first_x  <= ax;
    in_first_y  <= ay;
    in_first_z  <= az;
    in_second_x <= bx;
    in_second_y <= by;
    in_second_z <= bz;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps offering.
  initial begin
    int stall_len;
    int run_len;
    bit held;
    held = 0;
    out_stall <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held && items_sent >= 120) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (500) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end
      stall_len = idle_cycles();
      run_len = ($urandom_range(9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 6);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (run_len) @(posedge clk);
    end
  end

  initial begin
    logic [23:0] a [3];
    logic [23:0] d [3];
    int k;
    items_sent = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_first_x <= '0;
    in_first_y <= '0;
    in_first_z <= '0;
    in_second_x <= '0;
    in_second_y <= '0;
    in_second_z <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero vectors on either side and on both.
    send_pair(0, 0, 0, 1, 2, 3);
    send_pair(5, 24'hFFFFF9, 9, 0, 0, 0);
    send_pair(0, 0, 0, 0, 0, 0);
    // Parallel, antiparallel and orthogonal pairs.
    send_pair(1, 2, 3, 2, 4, 6);
    send_pair(1, 2, 3, 24'hFFFFFF, 24'hFFFFFE, 24'hFFFFFD);
    send_pair(1, 0, 0, 0, 1, 0);
    send_pair(0, 0, 7, 3, 24'hFFFFFC, 0);
    // Extremes, including the most negative component.
    send_pair(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
    send_pair(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_pair(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_pair(24'h800000, 0, 0, 24'h7FFFFF, 0, 0);
    send_pair(24'h800000, 0, 0, 0, 24'h800000, 0);
    send_pair(24'h7FFFFF, 1, 0, 24'h7FFFFF, 0, 1);
    send_pair(24'h800000, 24'h7FFFFF, 1, 24'hFFFFFF, 1, 24'h800000);
    send_pair(1, 1, 1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFE);
    send_pair(24'hFFFFFF, 0, 0, 1, 0, 0);
    send_pair(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1, 0, 0);
    send_pair(3, 4, 0, 4, 3, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          for (int i = 0; i < 3; i++) begin
            a[i] = 24'($urandom());
            d[i] = 24'($urandom());
          end
        end
        4: begin
          for (int i = 0; i < 3; i++) begin
            a[i] = small_comp();
            d[i] = small_comp();
          end
        end
        5: begin
          for (int i = 0; i < 3; i++) begin
            a[i] = edge_comp();
            d[i] = edge_comp();
          end
        end
        6, 7: begin
          // Nearly parallel or antiparallel: scaled copy plus a little noise.
          k = $urandom_range(1, 3);
          for (int i = 0; i < 3; i++) begin
            a[i] = 24'($signed($urandom_range(0, 2097151)) - 1048576);
            d[i] = 24'($signed(a[i]) * k + $signed($urandom_range(0, 6)) - 3);
            if (n % 2 == 1) d[i] = -d[i];
          end
        end
        8: begin
          for (int i = 0; i < 3; i++) begin
            a[i] = 24'($urandom());
            d[i] = 24'($urandom());
          end
          if ($urandom_range(1)) a = '{0, 0, 0};
          else d = '{0, 0, 0};
        end
        default: begin
          for (int i = 0; i < 3; i++) begin
            a[i] = 24'($urandom());
            d[i] = small_comp();
          end
        end
      endcase
      send_pair(a[0], a[1], a[2], d[0], d[1], d[2]);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### vector3_angle_top.f
+incdir+rtl
rtl/v3a_pkg.sv
rtl/v3a_front.sv
rtl/v3a_root_cell.sv
rtl/v3a_cordic_cell.sv
rtl/vector3_angle_top.sv
rtl/vector3_angle_chk.sv
test/vector3_angle_checker.sv
test/vector3_angle_top_test.sv
